// ===== rtl/tpcs_pkg.sv =====
// tpcs_pkg: shared types and constants for the three-phase current sense block
// used by tpcs_ctrl, tpcs_datapath and three_phase_current_sense_top
// no dependencies
package tpcs_pkg;

  // sample and offset widths
  localparam int ADC_BITS    = 12;
  localparam int OFFSET_LOG2 = 6;
  localparam int OFFSET_SAMPLES = 1 << OFFSET_LOG2;
  localparam int OFF_W   = ADC_BITS + 4;
  localparam int SUM_W   = ADC_BITS + OFFSET_LOG2;
  localparam int CNT_W   = OFFSET_LOG2;
  localparam int GAIN_W  = 16;
  localparam int CUR_W   = 19;
  localparam int BUS_W   = 16;

  // datapath widths
  localparam int OPD_W   = OFF_W + 1;          // signed multiplier operand
  localparam int PROD_W  = 2 * OPD_W;          // signed product
  localparam int MIX_W   = PROD_W + 2;         // 2*p_x - p_y - p_z
  localparam int CURR_SHIFT = 20;              // count * gain >> 16, 4 fraction bits
  localparam int BUS_SHIFT  = 12;
  localparam int QUO_W   = MIX_W - CURR_SHIFT; // floor of mix over 2^20
  localparam int TWO_W   = PROD_W - CURR_SHIFT;
  localparam int SEL_W   = 2;

  // floor division by three: bias into positive range, then reciprocal multiply
  localparam logic [QUO_W-1:0] MIX_BIAS      = QUO_W'(16386);
  localparam logic [QUO_W:0]   MIX_BIAS_DIV3 = (QUO_W+1)'(5462);
  localparam logic [OPD_W-1:0] DIV3_RECIP    = OPD_W'(43691);
  localparam int               DIV3_SHIFT    = 17;

  localparam logic [OFF_W-1:0] OFFSET_MID = OFF_W'(1 << (ADC_BITS + 3));
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  localparam int SAT_W = CUR_W + 2;
  localparam logic signed [SAT_W-1:0] CUR_MAX = SAT_W'(262143);
  localparam logic signed [SAT_W-1:0] CUR_MIN = -SAT_W'(262144);

  // item modes
  typedef enum logic [1:0] {
    MODE_CAL   = 2'd0,
    MODE_THREE = 2'd1,
    MODE_TWO   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // phase selector codes
  typedef enum logic [1:0] {
    PH_A    = 2'd0,
    PH_B    = 2'd1,
    PH_C    = 2'd2,
    PH_NONE = 2'd3
  } phase_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CURRENT_GAIN   = 2'd0,
    CFG_CURRENT_NEGATE = 2'd1,
    CFG_BUS_GAIN       = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic             mix_en;
    logic             div_en;
    logic [SEL_W-1:0] sel;
    logic             out_load;
  } dp_cmd_t;

  function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [SAT_W-1:0] v);
    logic signed [CUR_W-1:0] r;
    if (v > CUR_MAX) begin
      r = CUR_MAX[CUR_W-1:0];
    end else if (v < CUR_MIN) begin
      r = CUR_MIN[CUR_W-1:0];
    end else begin
      r = v[CUR_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/tpcs_ctrl.sv =====
// tpcs_ctrl: sequencer for the current sense datapath
// depends on tpcs_pkg
module tpcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tpcs_pkg::dp_cmd_t cmd_o
);
  import tpcs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_MIX   = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  localparam logic [SEL_W-1:0] MUL_LAST = SEL_W'(3);
  localparam logic [SEL_W-1:0] DIV_LAST = SEL_W'(2);

  state_e           state_q, state_d;
  logic [SEL_W-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.sel = step_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_accept;
        if (in_accept) begin
          state_d = S_MUL;
          step_d  = '0;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_q == MUL_LAST) begin
          state_d = S_MIX;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_MIX: begin
        cmd_o.mix_en = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        if (step_q == DIV_LAST) begin
          state_d = S_WRITE;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // an accepted word always starts the multiply sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_MUL) && (step_q == '0))
    else $error("accepted word did not start multiply sequence");

  // a result word is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

  // divide steps only address the three phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q != MUL_LAST))
    else $error("divide step out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

// ===== rtl/tpcs_datapath.sv =====
// tpcs_datapath: calibration state, config registers, shared multiplier and
// result registers of the current sense block; depends on tpcs_pkg
module tpcs_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tpcs_pkg::dp_cmd_t                  cmd_i,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic [1:0]                         mode_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_phase_a_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_phase_b_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_phase_c_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_bus_i,
  input  logic [1:0]                         shunt_first_i,
  input  logic [1:0]                         shunt_second_i,
  output logic signed [tpcs_pkg::CUR_W-1:0]  current_a_o,
  output logic signed [tpcs_pkg::CUR_W-1:0]  current_b_o,
  output logic signed [tpcs_pkg::CUR_W-1:0]  current_c_o,
  output logic [tpcs_pkg::BUS_W-1:0]         bus_voltage_o,
  output logic                               is_calibrated_o,
  output logic                               pair_invalid_o
);
  import tpcs_pkg::*;

  // config registers
  logic [GAIN_W-1:0] current_gain_q;
  logic              current_negate_q;
  logic [GAIN_W-1:0] bus_gain_q;

  // calibration state
  logic [OFF_W-1:0] offset_q [3];
  logic [SUM_W-1:0] sum_q [3];
  logic [SUM_W-1:0] sum_d [3];
  logic [CNT_W-1:0] count_q;
  logic             done_q;
  logic             cal_last;

  // captured word
  logic [ADC_BITS-1:0] raw_q [3];
  logic [ADC_BITS-1:0] bus_raw_q;
  logic [1:0]          mode_q;
  logic [1:0]          first_q;
  logic [1:0]          second_q;

  // working registers
  logic signed [PROD_W-1:0] prod_q [3];
  logic [BUS_W-1:0]         bus_q;
  logic [QUO_W-1:0]         biased_q [3];
  logic signed [TWO_W-1:0]  two_q [3];
  logic [QUO_W-1:0]         quo3_q [3];

  // shared multiplier
  logic signed [OPD_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p, prod_sgn;
  logic signed [OPD_W-1:0]  diff;
  logic [ADC_BITS-1:0]      raw_sel;
  logic [OFF_W-1:0]         off_sel;

  // mean removal
  logic signed [MIX_W-1:0]  mix [3];

  // final selection
  logic                     invalid;
  logic signed [SAT_W-1:0]  three_val [3];
  logic signed [SAT_W-1:0]  two_val [3];
  logic signed [CUR_W-1:0]  cur_sel [3];
  logic                     is_meas [3];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_gain_q   <= GAIN_RESET;
      current_negate_q <= 1'b0;
      bus_gain_q       <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CURRENT_GAIN:   current_gain_q   <= cfg_data_i;
        CFG_CURRENT_NEGATE: current_negate_q <= cfg_data_i[0];
        CFG_BUS_GAIN:       bus_gain_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // running sums for offset calibration
  assign sum_d[0] = sum_q[0] + SUM_W'(raw_phase_a_i);
  assign sum_d[1] = sum_q[1] + SUM_W'(raw_phase_b_i);
  assign sum_d[2] = sum_q[2] + SUM_W'(raw_phase_c_i);
  assign cal_last = (count_q == CNT_W'(OFFSET_SAMPLES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        offset_q[i] <= OFFSET_MID;
        sum_q[i]    <= '0;
      end
      count_q <= '0;
      done_q  <= 1'b0;
    end else if (cmd_i.load && (mode_i == MODE_CAL)) begin
      if (cal_last) begin
        for (int i = 0; i < 3; i++) begin
          offset_q[i] <= OFF_W'({sum_d[i], 4'b0} >> OFFSET_LOG2);
          sum_q[i]    <= '0;
        end
        count_q <= '0;
        done_q  <= 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_d[i];
        end
        count_q <= count_q + 1'b1;
      end
    end
  end

  // capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q[0]  <= raw_phase_a_i;
      raw_q[1]  <= raw_phase_b_i;
      raw_q[2]  <= raw_phase_c_i;
      bus_raw_q <= raw_bus_i;
      mode_q    <= mode_i;
      first_q   <= shunt_first_i;
      second_q  <= shunt_second_i;
    end
  end

  // multiplier operand select: phase products, bus product, divide by three
  always_comb begin
    raw_sel = '0;
    off_sel = '0;
    if (cmd_i.sel != PH_NONE) begin
      raw_sel = raw_q[cmd_i.sel];
      off_sel = offset_q[cmd_i.sel];
    end
    diff = $signed({1'b0, raw_sel, 4'b0}) - $signed({1'b0, off_sel});
    if (cmd_i.div_en) begin
      mul_a = $signed({1'b0, biased_q[cmd_i.sel]});
      mul_b = $signed(DIV3_RECIP);
    end else if (cmd_i.sel == PH_NONE) begin
      mul_a = $signed(OPD_W'(bus_raw_q));
      mul_b = $signed({1'b0, bus_gain_q});
    end else begin
      mul_a = diff;
      mul_b = $signed({1'b0, current_gain_q});
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_sgn = current_negate_q ? -mul_p : mul_p;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      if (cmd_i.sel == PH_NONE) begin
        bus_q <= mul_p[BUS_SHIFT +: BUS_W];
      end else begin
        prod_q[cmd_i.sel] <= prod_sgn;
      end
    end
    if (cmd_i.div_en && (cmd_i.sel != PH_NONE)) begin
      quo3_q[cmd_i.sel] <= mul_p[DIV3_SHIFT +: QUO_W];
    end
  end

  // mean removal and two-shunt rounding
  assign mix[0] = (MIX_W'(prod_q[0]) <<< 1) - MIX_W'(prod_q[1]) - MIX_W'(prod_q[2]);
  assign mix[1] = (MIX_W'(prod_q[1]) <<< 1) - MIX_W'(prod_q[0]) - MIX_W'(prod_q[2]);
  assign mix[2] = (MIX_W'(prod_q[2]) <<< 1) - MIX_W'(prod_q[0]) - MIX_W'(prod_q[1]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix_en) begin
      for (int i = 0; i < 3; i++) begin
        biased_q[i] <= mix[i][CURR_SHIFT +: QUO_W] + MIX_BIAS;
        two_q[i]    <= prod_q[i][CURR_SHIFT +: TWO_W];
      end
    end
  end

  // per-phase result by mode
  assign invalid = (first_q == PH_NONE) || (second_q == PH_NONE) || (first_q == second_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      three_val[i] = SAT_W'($signed({1'b0, quo3_q[i]}) - $signed(MIX_BIAS_DIV3));
      is_meas[i]   = (first_q == 2'(i)) || (second_q == 2'(i));
    end
    two_val[0] = is_meas[0] ? SAT_W'(two_q[0]) : -(SAT_W'(two_q[1]) + SAT_W'(two_q[2]));
    two_val[1] = is_meas[1] ? SAT_W'(two_q[1]) : -(SAT_W'(two_q[0]) + SAT_W'(two_q[2]));
    two_val[2] = is_meas[2] ? SAT_W'(two_q[2]) : -(SAT_W'(two_q[0]) + SAT_W'(two_q[1]));
    for (int i = 0; i < 3; i++) begin
      case (mode_q)
        MODE_THREE: cur_sel[i] = sat_cur(three_val[i]);
        MODE_TWO:   cur_sel[i] = invalid ? '0 : sat_cur(two_val[i]);
        default:    cur_sel[i] = '0;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      current_a_o     <= cur_sel[0];
      current_b_o     <= cur_sel[1];
      current_c_o     <= cur_sel[2];
      bus_voltage_o   <= bus_q;
      is_calibrated_o <= done_q;
      pair_invalid_o  <= (mode_q == MODE_TWO) && invalid;
    end
  end

endmodule

// ===== rtl/three_phase_current_sense_top.sv =====
// three_phase_current_sense_top: phase current and bus voltage conversion with
// offset calibration; an accepted word passes the multiply, mix, divide and write
// states before the next word is taken, set by the single shared 17x17 multiplier
// (three phase products, one bus product, three divide-by-three steps)
// a finished result waits in the output register while the next word is taken
// rst_ni async active low: gains 4096, offsets mid-scale, calibration cleared
module three_phase_current_sense_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         mode_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_phase_a_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_phase_b_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_phase_c_i,
  input  logic [tpcs_pkg::ADC_BITS-1:0]      raw_bus_i,
  input  logic [1:0]                         shunt_first_i,
  input  logic [1:0]                         shunt_second_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tpcs_pkg::CUR_W-1:0]  current_a_o,
  output logic signed [tpcs_pkg::CUR_W-1:0]  current_b_o,
  output logic signed [tpcs_pkg::CUR_W-1:0]  current_c_o,
  output logic [tpcs_pkg::BUS_W-1:0]         bus_voltage_o,
  output logic                               is_calibrated_o,
  output logic                               pair_invalid_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i
);
  import tpcs_pkg::*;

  dp_cmd_t cmd;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  tpcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tpcs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .raw_phase_a_i   (raw_phase_a_i),
    .raw_phase_b_i   (raw_phase_b_i),
    .raw_phase_c_i   (raw_phase_c_i),
    .raw_bus_i       (raw_bus_i),
    .shunt_first_i   (shunt_first_i),
    .shunt_second_i  (shunt_second_i),
    .current_a_o     (current_a_o),
    .current_b_o     (current_b_o),
    .current_c_o     (current_c_o),
    .bus_voltage_o   (bus_voltage_o),
    .is_calibrated_o (is_calibrated_o),
    .pair_invalid_o  (pair_invalid_o)
  );

endmodule
